[rtl/kfti_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfti_pkg
// shared types and codes of the keyframe time to fractional index core
// ----------------------------------------------------------------------------
package kfti_pkg;

    localparam int TIME_W  = 32;
    localparam int INDEX_W = 24;
    localparam int STS_W   = 2;
    localparam int FRAC_W  = 16;
    localparam int QUOT_W  = FRAC_W + 1;
    localparam int DCNT_W  = 5;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic [STS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STS_BELOW = 2'd1;
    localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APPEND,
        ST_SEARCH,
        ST_CMP,
        ST_PREV,
        ST_NEXT,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                done;
        logic [QUOT_W-1:0]   quot;
    } t_div_rsp;

endpackage

[rtl/kfti_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfti_mem
// frame time table, one write and one registered read port
// ----------------------------------------------------------------------------
module kfti_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [kfti_pkg::TIME_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [kfti_pkg::TIME_W-1:0] o_rdata
);

    logic [kfti_pkg::TIME_W-1:0] r_mem [DEPTH];
    logic [kfti_pkg::TIME_W-1:0] r_q;
    logic                        r_rd_zero;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    // entry zero is never written and always reads as time zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_zero <= 1'b0;
        end else if (i_re) begin
            r_rd_zero <= (i_raddr == '0);
        end
    end

    assign o_rdata = r_rd_zero ? '0 : r_q;

endmodule

[rtl/kfti_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfti_div
// restoring divider for the interpolation fraction, one quotient bit a cycle
// ----------------------------------------------------------------------------
module kfti_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [kfti_pkg::TIME_W-1:0] i_num,
    input  logic [kfti_pkg::TIME_W-1:0] i_den,
    output kfti_pkg::t_div_rsp          o_rsp
);

    logic                              r_busy;
    logic                              r_done;
    logic [kfti_pkg::DCNT_W-1:0]       r_cnt;
    logic [kfti_pkg::TIME_W:0]         r_rem;
    logic [kfti_pkg::TIME_W-1:0]       r_den;
    logic [kfti_pkg::QUOT_W-1:0]       r_quot;
    logic                              first;
    logic [kfti_pkg::TIME_W:0]         trial;
    logic [kfti_pkg::TIME_W+1:0]       diff;
    logic                              q_bit;

    // numerator never exceeds the divisor, so the top bit needs no shift
    assign first = (r_cnt == kfti_pkg::DCNT_W'(kfti_pkg::QUOT_W - 1));
    assign trial = first ? r_rem : {r_rem[kfti_pkg::TIME_W-1:0], 1'b0};
    assign diff  = {1'b0, trial} - {2'b00, r_den};
    assign q_bit = ~diff[kfti_pkg::TIME_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= kfti_pkg::DCNT_W'(kfti_pkg::QUOT_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= q_bit ? diff[kfti_pkg::TIME_W:0] : trial;
            r_quot <= {r_quot[kfti_pkg::QUOT_W-2:0], q_bit};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

[rtl/keyframe_time_to_fractional_index_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_time_to_fractional_index_core
// sorted frame time table with lower-bound search and interpolated index
// ----------------------------------------------------------------------------
// One command is worked at a time. An append passes the append state and
// then loads its result. Each binary-search step of a query is one table
// read and one compare, at most ceil(log2(entries)) steps, 8 for a full
// 256-entry table, then a closing search step. A query that lands on
// position zero then loads its result. Any other query reads the two neighbor
// entries, runs the divider (17 quotient bits, one bit per cycle, then the
// quotient is handed over) and loads the result. The controller is back in
// idle when the result register loads, and only then takes the next transfer.
// The single read port of the table and the serial divider keep both the
// search and the fraction serial.
// The result sits in an output register, so a new command is taken while the
// last result waits; a finished command holds until that result has left.
module keyframe_time_to_fractional_index_core #(
    parameter int MAX_FRAMES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // time_value
    input  logic        s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // frame_index[23:0], status[25:24], zero
);

    localparam int AW = (MAX_FRAMES > 2) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW = $clog2(MAX_FRAMES + 1);

    kfti_pkg::t_state r_state, n_state;

    logic [CW-1:0]                 r_count;
    logic [kfti_pkg::TIME_W-1:0]   r_last;
    logic [kfti_pkg::TIME_W-1:0]   r_t;
    logic                          r_cmd;
    logic [AW-1:0]                 r_lo;
    logic [AW-1:0]                 r_hi;
    logic [AW-1:0]                 r_mid;
    logic [kfti_pkg::TIME_W-1:0]   r_prev;
    logic [kfti_pkg::INDEX_W-1:0]  r_res_idx;
    logic [kfti_pkg::STS_W-1:0]    r_res_sts;
    logic                          r_out_valid;
    logic [31:0]                   r_out_data;

    logic                          accept;
    logic [kfti_pkg::TIME_W-1:0]   t_in;
    logic [kfti_pkg::TIME_W-1:0]   t_clip;
    logic [AW-1:0]                 mid;
    logic                          below;
    logic                          full;
    logic                          out_free;
    logic                          mem_we;
    logic                          mem_re;
    logic [AW-1:0]                 mem_raddr;
    logic [kfti_pkg::TIME_W-1:0]   rd_data;
    logic                          div_start;
    kfti_pkg::t_div_rsp            div_rsp;
    logic [kfti_pkg::INDEX_W-1:0]  idx_base;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign t_in     = s_axis_tdata;
    assign out_free = !r_out_valid || m_axis_tready;
    assign mid      = r_lo + ((r_hi - r_lo) >> 1);

    // stored times are never negative, so the clip is an unsigned compare
    always_comb begin
        if (t_in[kfti_pkg::TIME_W-1]) begin
            t_clip = '0;
        end else if (t_in > r_last) begin
            t_clip = r_last;
        end else begin
            t_clip = t_in;
        end
    end

    assign below = r_t[kfti_pkg::TIME_W-1] || (r_t < r_last);
    assign full  = (r_count >= CW'(MAX_FRAMES));
    assign idx_base = kfti_pkg::INDEX_W'(r_lo - AW'(1)) << kfti_pkg::FRAC_W;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kfti_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = (s_axis_tuser == kfti_pkg::CMD_QUERY) ?
                              kfti_pkg::ST_SEARCH : kfti_pkg::ST_APPEND;
                end
            end
            kfti_pkg::ST_APPEND: n_state = kfti_pkg::ST_OUT;
            kfti_pkg::ST_SEARCH: begin
                if (r_lo < r_hi) begin
                    n_state = kfti_pkg::ST_CMP;
                end else if (r_lo == '0) begin
                    n_state = kfti_pkg::ST_OUT;
                end else begin
                    n_state = kfti_pkg::ST_PREV;
                end
            end
            kfti_pkg::ST_CMP:  n_state = kfti_pkg::ST_SEARCH;
            kfti_pkg::ST_PREV: n_state = kfti_pkg::ST_NEXT;
            kfti_pkg::ST_NEXT: n_state = kfti_pkg::ST_DIV;
            kfti_pkg::ST_DIV: begin
                if (div_rsp.done) begin
                    n_state = kfti_pkg::ST_OUT;
                end
            end
            kfti_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = kfti_pkg::ST_IDLE;
                end
            end
            default: n_state = kfti_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_raddr     = r_lo;
        div_start     = 1'b0;
        unique case (r_state)
            kfti_pkg::ST_IDLE:   s_axis_tready = 1'b1;
            kfti_pkg::ST_APPEND: mem_we = !below && !full;
            kfti_pkg::ST_SEARCH: begin
                if (r_lo < r_hi) begin
                    mem_re    = 1'b1;
                    mem_raddr = mid;
                end else if (r_lo != '0) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_lo - AW'(1);
                end
            end
            kfti_pkg::ST_PREV: begin
                mem_re    = 1'b1;
                mem_raddr = r_lo;
            end
            kfti_pkg::ST_NEXT: div_start = 1'b1;
            kfti_pkg::ST_CMP, kfti_pkg::ST_DIV, kfti_pkg::ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kfti_pkg::ST_IDLE;
            r_count     <= CW'(1);
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mem_we) begin
                r_count <= r_count + 1'b1;
                r_last  <= r_t;
            end
            if (r_state == kfti_pkg::ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= s_axis_tuser;
            r_t   <= (s_axis_tuser == kfti_pkg::CMD_QUERY) ? t_clip : t_in;
            r_lo  <= '0;
            r_hi  <= AW'(r_count - 1'b1);
        end
        unique case (r_state)
            kfti_pkg::ST_APPEND: begin
                r_res_idx <= '0;
                if (below) begin
                    r_res_sts <= kfti_pkg::STS_BELOW;
                end else if (full) begin
                    r_res_sts <= kfti_pkg::STS_FULL;
                end else begin
                    r_res_sts <= kfti_pkg::STS_OK;
                end
            end
            kfti_pkg::ST_SEARCH: begin
                r_mid <= mid;
                if (!(r_lo < r_hi) && r_lo == '0) begin
                    r_res_idx <= '0;
                    r_res_sts <= kfti_pkg::STS_OK;
                end
            end
            kfti_pkg::ST_CMP: begin
                if (rd_data < r_t) begin
                    r_lo <= r_mid + AW'(1);
                end else begin
                    r_hi <= r_mid;
                end
            end
            kfti_pkg::ST_PREV: r_prev <= rd_data;
            kfti_pkg::ST_DIV: begin
                if (div_rsp.done) begin
                    r_res_idx <= idx_base + kfti_pkg::INDEX_W'(div_rsp.quot);
                    r_res_sts <= kfti_pkg::STS_OK;
                end
            end
            kfti_pkg::ST_IDLE, kfti_pkg::ST_NEXT, kfti_pkg::ST_OUT: begin
            end
            default: begin
            end
        endcase
        if (r_state == kfti_pkg::ST_OUT && out_free) begin
            r_out_data <= {6'b0, r_res_sts, r_res_idx};
        end
    end

    kfti_mem #(
        .DEPTH (MAX_FRAMES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_t),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rd_data)
    );

    // fraction: (t - prev) * 2^16 / (next - prev), next arrives this cycle
    kfti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_t - r_prev),
        .i_den   (rd_data - r_prev),
        .o_rsp   (div_rsp)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_count_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= CW'(MAX_FRAMES)))
        else $error("entry count out of range");

    a_search_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kfti_pkg::ST_SEARCH) |-> (r_lo <= r_hi))
        else $error("search bounds crossed");

    a_div_owner : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == kfti_pkg::ST_DIV))
        else $error("divider finished outside its wait state");

    a_frac_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (div_rsp.quot <= 17'h10000))
        else $error("interpolation fraction above one");

    a_query_path : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && s_axis_tuser == kfti_pkg::CMD_QUERY) |=>
        (r_state == kfti_pkg::ST_SEARCH && r_cmd == kfti_pkg::CMD_QUERY))
        else $error("query transfer did not start a search");

endmodule

[verif/kfti_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfti_checker
// watches both streams of the keyframe index core, keeps its own copy of the
// frame time table, predicts each result and compares it field by field
// ----------------------------------------------------------------------------
module kfti_checker #(
    parameter int MAX_FRAMES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  logic        i_cmd_ready,
    input  logic [31:0] i_cmd_time,
    input  logic        i_cmd_kind,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [31:0] i_rsp_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int IW = kfti_pkg::INDEX_W;
    localparam int SW = kfti_pkg::STS_W;
    localparam int TW = kfti_pkg::TIME_W;

    typedef struct packed {
        logic [IW-1:0] frame_index;
        logic [SW-1:0] status;
    } t_lookup_rsp;

    logic [TW-1:0] frame_time [MAX_FRAMES];
    int unsigned   entry_cnt;
    t_lookup_rsp   lookup_q [$];
    t_lookup_rsp   want;
    int            fails;

    // lower-bound search then interpolation between the two neighbors
    function automatic logic [IW-1:0] interp_index(input logic [TW-1:0] t);
        logic [TW-1:0] last;
        logic [TW-1:0] tc;
        logic [TW-1:0] prev;
        logic [TW-1:0] next;
        logic [47:0]   num;
        logic [47:0]   frac;
        logic [31:0]   idx;
        int unsigned   lo;
        int unsigned   hi;
        int unsigned   mid;
        last = frame_time[entry_cnt-1];
        if (t[TW-1]) begin
            tc = '0;
        end else if (t > last) begin
            tc = last;
        end else begin
            tc = t;
        end
        lo = 0;
        hi = entry_cnt - 1;
        while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            if (frame_time[mid] < tc) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        if (lo == 0) begin
            return '0;
        end
        prev = frame_time[lo-1];
        next = frame_time[lo];
        num  = {tc - prev, 16'h0000};
        frac = num / {16'h0000, next - prev};
        idx  = ((lo - 1) << kfti_pkg::FRAC_W) + frac[31:0];
        return idx[IW-1:0];
    endfunction

    function automatic t_lookup_rsp run_command(input logic kind,
                                                 input logic [TW-1:0] t);
        t_lookup_rsp r;
        logic [TW-1:0] last;
        r.frame_index = '0;
        r.status      = kfti_pkg::STS_OK;
        if (kind == kfti_pkg::CMD_APPEND) begin
            last = frame_time[entry_cnt-1];
            // negative times always fall below the last entry
            if (t[TW-1] || t < last) begin
                r.status = kfti_pkg::STS_BELOW;
            end else if (entry_cnt >= MAX_FRAMES) begin
                r.status = kfti_pkg::STS_FULL;
            end else begin
                frame_time[entry_cnt] = t;
                entry_cnt++;
            end
        end else begin
            r.frame_index = interp_index(t);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            entry_cnt     = 1;
            frame_time[0] = '0;
            fails         = 0;
            lookup_q.delete();
        end else begin
            if (i_cmd_valid && i_cmd_ready) begin
                lookup_q.insert(lookup_q.size(), run_command(i_cmd_kind, i_cmd_time));
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (lookup_q.size() == 0) begin
                    $error("result transfer with nothing expected: data %h", i_rsp_data);
                    fails++;
                end else begin
                    want = lookup_q.pop_front();
                    if (i_rsp_data[IW-1:0] !== want.frame_index) begin
                        $error("frame_index mismatch: expected %h, actual %h",
                               want.frame_index, i_rsp_data[IW-1:0]);
                        fails++;
                    end
                    if (i_rsp_data[IW+SW-1:IW] !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, i_rsp_data[IW+SW-1:IW]);
                        fails++;
                    end
                    if (i_rsp_data[31:IW+SW] !== '0) begin
                        $error("padding mismatch: expected %h, actual %h",
                               6'h00, i_rsp_data[31:IW+SW]);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= lookup_q.size();
        o_fail_count <= fails;
    end

endmodule

[verif/tb_keyframe_time_to_fractional_index_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyframe_time_to_fractional_index_core
// drives appends and queries into the keyframe index core with random gaps
// on both streams; a checker beside the core predicts and compares results
// ----------------------------------------------------------------------------
module tb_keyframe_time_to_fractional_index_core;

    localparam int MAX_FRAMES = 256;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // time_value
    logic        s_axis_tuser;   // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // frame_index[23:0], status[25:24], zero

    int          fail_count;
    int          pending;
    logic        quiet;
    logic [31:0] frame_log [$];

    keyframe_time_to_fractional_index_core #(
        .MAX_FRAMES(MAX_FRAMES)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    kfti_checker #(
        .MAX_FRAMES(MAX_FRAMES)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (s_axis_tvalid),
        .i_cmd_ready (s_axis_tready),
        .i_cmd_time  (s_axis_tdata),
        .i_cmd_kind  (s_axis_tuser),
        .i_rsp_valid (m_axis_tvalid),
        .i_rsp_ready (m_axis_tready),
        .i_rsp_data  (m_axis_tdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // mostly short gaps, now and then a long one, none in quiet stretches
    function automatic int gap_len();
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 60);
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic drive_item(input logic kind, input logic [31:0] t);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= t;
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        gap = gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // keeps a log of stored times so appends and queries can be aimed
    task automatic send_append(input logic [31:0] t);
        logic [31:0] last;
        last = frame_log[$];
        drive_item(kfti_pkg::CMD_APPEND, t);
        if (!t[31] && t >= last && frame_log.size() < MAX_FRAMES) begin
            frame_log.insert(frame_log.size(), t);
        end
    endtask

    task automatic send_query(input logic [31:0] t);
        drive_item(kfti_pkg::CMD_QUERY, t);
    endtask

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            if (gap_len() > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap_len() + 1) @(negedge i_clk);
            end
        end
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int          n;
        int          r;
        int          r2;
        logic [31:0] last;
        logic [31:0] t;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = kfti_pkg::CMD_APPEND;
        quiet         = 1'b0;
        frame_log.insert(0, 32'h0);
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // single-entry table: every query lands on position zero
        send_query(32'h0000_0000);
        send_query(32'h7FFF_FFFF);
        send_query(32'h8000_0000);
        // negative appends are always below the last entry
        send_append(32'h8000_0000);
        send_append(32'hFFFF_FFFF);
        send_append(32'h0000_0000);
        send_append(32'h0001_0000);
        send_append(32'h0001_0000);
        send_append(32'h0003_0000);
        send_append(32'h0000_8000);
        // duplicates: lower bound must pick the first equal entry
        send_query(32'h0000_8000);
        send_query(32'h0001_0000);
        send_query(32'h0000_0000);
        send_query(32'h0002_0001);
        send_query(32'h0003_0000);
        send_query(32'h0004_0000);
        send_query(32'hFFFF_FFFF);

        for (n = 0; n < 1650; n++) begin
            quiet = ((n % 400) >= 340);
            if (n == 800) begin
                // hold the sender until every result has come back
                s_axis_tvalid <= 1'b0;
                while (pending != 0) @(negedge i_clk);
            end
            last = frame_log[$];
            r    = $urandom_range(0, 99);
            r2   = $urandom_range(0, 99);
            if (r < 16 && frame_log.size() < 250) begin
                if (r2 < 60) begin
                    t = last + $urandom_range(1, 1 << 18);
                end else if (r2 < 80) begin
                    t = last;
                end else if (r2 < 95) begin
                    t = last + $urandom_range(1, 16);
                end else begin
                    t = last + $urandom_range(1 << 18, 1 << 22);
                end
                send_append(t);
            end else if (r < 20) begin
                if (r2 < 50 || last == 0) begin
                    send_append($urandom() | 32'h8000_0000);
                end else begin
                    send_append($urandom_range(0, last - 1));
                end
            end else begin
                if (r2 < 55) begin
                    t = $urandom_range(0, last);
                end else if (r2 < 70) begin
                    t = frame_log[$urandom_range(0, frame_log.size() - 1)];
                    t = t + $urandom_range(0, 2) - 1;
                end else if (r2 < 80) begin
                    t = $urandom() | 32'h8000_0000;
                end else if (r2 < 90) begin
                    t = $urandom_range(last, 32'h7FFF_FFFF);
                end else begin
                    t = $urandom();
                end
                send_query(t);
            end
        end

        // fill the table, then the largest time and the full-table cases
        quiet = 1'b0;
        while (frame_log.size() < MAX_FRAMES - 2) begin
            send_append(frame_log[$] + $urandom_range(1, 1 << 16));
        end
        last = frame_log[$];
        send_append(32'h7FFF_FFFF);
        send_query(32'h7FFF_FFFF);
        send_query(32'h7FFF_0000);
        send_query(last + 1);
        send_append(32'h7FFF_FFFF);
        send_append(32'h7FFF_FFFF);
        // below the last entry and full at once: the time check wins
        send_append(32'h0000_0001);
        send_append(32'h8000_0000);
        for (n = 0; n < 20; n++) begin
            send_query($urandom());
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
